// ===== sv/tiny_cpu_instruction_execute_macros.svh =====
// assertion macros for the tiny cpu instruction execute block
// expects clk_i and rst_ni in the scope of the including module
`ifndef TINY_CPU_INSTRUCTION_EXECUTE_MACROS_SVH
`define TINY_CPU_INSTRUCTION_EXECUTE_MACROS_SVH

// checked outside reset only
`define TCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define TCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/tce_pkg.sv =====
// shared types, constants and decode functions of the tiny cpu execute block
// no dependencies
`default_nettype none

package tce_pkg;

  localparam int unsigned RAM_DEPTH_DEF = 1024;
  localparam int unsigned WORD_W        = 16;
  localparam int unsigned NREG          = 8;
  localparam int unsigned RIDX_W        = 3;

  typedef enum logic [3:0] {
    OP_MOV, OP_MOVI, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_INC, OP_DEC,
    OP_AND, OP_OR, OP_XOR, OP_NOT, OP_JMP, OP_JZ, OP_JN, OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_REG  = 2'd1,
    K_IMM  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK, ST_TYPE, ST_BADREG, ST_BADOP
  } status_e;

  typedef struct packed {
    status_e             status;
    op_e                 opcode;
    logic [RIDX_W-1:0]   rd;
    logic [RIDX_W-1:0]   rs;
    logic [RIDX_W-1:0]   rt;
    logic [WORD_W-1:0]   imm1;
    logic [WORD_W-1:0]   imm2;
  } inst_t;

  // operand kinds an opcode needs, packed as {op3, op2, op1}
  function automatic logic [5:0] need_kinds(op_e op);
    logic [5:0] k;
    unique case (op) inside
      OP_MOV, OP_LOAD, OP_STORE, OP_INC, OP_DEC, OP_NOT: k = {K_NONE, K_REG, K_REG};
      OP_MOVI, OP_JZ, OP_JN:                            k = {K_NONE, K_IMM, K_REG};
      OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR:            k = {K_REG, K_REG, K_REG};
      OP_JMP:                                           k = {K_NONE, K_NONE, K_IMM};
      OP_OUT:                                           k = {K_NONE, K_NONE, K_REG};
      default:                                          k = {K_NONE, K_NONE, K_NONE};
    endcase
    return k;
  endfunction

  // opcodes that write the register file
  function automatic logic writes_reg(op_e op);
    logic w;
    unique case (op) inside
      OP_MOV, OP_MOVI, OP_LOAD, OP_ADD, OP_SUB, OP_INC, OP_DEC,
      OP_AND, OP_OR, OP_XOR, OP_NOT: w = 1'b1;
      default:                       w = 1'b0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tiny_cpu_instruction_execute.sv =====
// Executes one instruction per item of a small 16-bit machine: eight registers, a word
// addressed data ram and a program counter, one result item per instruction. Sustained
// rate is one instruction per cycle while no load, address wait or result back-pressure
// holds the execute stage. A load takes a further PH_LOAD step, as the data ram read is
// registered. When RAM_DEPTH is not a power of two, loads and stores wait in the reciprocal
// multiply address remainder unit through its S_QUO and S_REM states. After reset a
// clearing pass zeroes the data ram, during which no item is accepted; configuration writes
// are taken. depends on tce_pkg, tce_front, tce_queue, tce_back and the assertion macro header
`default_nettype none

`include "tiny_cpu_instruction_execute_macros.svh"

module tiny_cpu_instruction_execute import tce_pkg::*; #(
  parameter int unsigned RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         opcode_i,
  input  wire logic [1:0]         op1_type_i,
  input  wire logic signed [15:0] op1_value_i,
  input  wire logic [1:0]         op2_type_i,
  input  wire logic signed [15:0] op2_value_i,
  input  wire logic [1:0]         op3_type_i,
  input  wire logic signed [15:0] op3_value_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic [1:0]              status_o,
  output logic [15:0]             next_pc_o,
  output logic                    out_valid_o,
  output logic [2:0]              out_register_o,
  output logic signed [15:0]      out_value_o
);

  logic              cfg_we;
  logic [WORD_W-1:0] origin;
  logic              clr_busy;
  logic              push;
  logic              q_ready;
  logic              q_vld;
  logic              pop;
  inst_t             f_inst;
  inst_t             q_head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {16'd0, origin};

  tce_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .op1_type_i  (op1_type_i),
    .op1_value_i (op1_value_i),
    .op2_type_i  (op2_type_i),
    .op2_value_i (op2_value_i),
    .op3_type_i  (op3_type_i),
    .op3_value_i (op3_value_i),
    .q_ready_i   (q_ready),
    .clr_busy_i  (clr_busy),
    .push_o      (push),
    .inst_o      (f_inst)
  );

  tce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .inst_i  (f_inst),
    .ready_o (q_ready),
    .pop_i   (pop),
    .vld_o   (q_vld),
    .head_o  (q_head)
  );

  tce_back #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_vld_i        (q_vld),
    .q_inst_i       (q_head),
    .q_pop_o        (pop),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[WORD_W-1:0]),
    .origin_o       (origin),
    .clr_busy_o     (clr_busy),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .status_o       (status_o),
    .next_pc_o      (next_pc_o),
    .out_valid_o    (out_valid_o),
    .out_register_o (out_register_o),
    .out_value_o    (out_value_o)
  );

  `TCE_ASSERT_ALWAYS(a_no_item_in_clear, clr_busy |-> !in_ready_o, "item taken during clear")
  `TCE_ASSERT(a_push_has_room, push |-> q_ready, "queue overflow")
  `TCE_ASSERT(a_pop_has_item, pop |-> q_vld, "queue underflow")
  `TCE_ASSERT(a_out_only_ok, (res_valid_o && out_valid_o) |-> (status_o == ST_OK),
              "output flagged on failed item")

endmodule

`default_nettype wire

// ===== sv/tce_ram.sv =====
// generic single write port ram with registered, enabled read
// no dependencies
`default_nettype none

module tce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/tce_front.sv =====
// front end: takes input items, checks operand kinds and register indices
// depends on tce_pkg
`default_nettype none

module tce_front import tce_pkg::*; (
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         opcode_i,
  input  wire logic [1:0]         op1_type_i,
  input  wire logic signed [15:0] op1_value_i,
  input  wire logic [1:0]         op2_type_i,
  input  wire logic signed [15:0] op2_value_i,
  input  wire logic [1:0]         op3_type_i,
  input  wire logic signed [15:0] op3_value_i,
  input  wire logic               q_ready_i,
  input  wire logic               clr_busy_i,
  output logic                    push_o,
  output inst_t                   inst_o
);

  op_e        op;
  logic [5:0] need;
  logic       mismatch;
  logic       badreg;

  assign op   = op_e'(opcode_i);
  assign need = need_kinds(op);

  assign mismatch = (op1_type_i != need[1:0]) || (op2_type_i != need[3:2]) ||
                    (op3_type_i != need[5:4]);
  assign badreg   = ((op1_type_i == K_REG) && (op1_value_i[15:3] != '0)) ||
                    ((op2_type_i == K_REG) && (op2_value_i[15:3] != '0)) ||
                    ((op3_type_i == K_REG) && (op3_value_i[15:3] != '0));

  assign in_ready_o = q_ready_i && !clr_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    inst_o.status = mismatch ? ST_TYPE : (badreg ? ST_BADREG : ST_OK);
    inst_o.opcode = op;
    inst_o.rd     = op1_value_i[RIDX_W-1:0];
    inst_o.rs     = op2_value_i[RIDX_W-1:0];
    inst_o.rt     = op3_value_i[RIDX_W-1:0];
    inst_o.imm1   = op1_value_i;
    inst_o.imm2   = op2_value_i;
  end

endmodule

`default_nettype wire

// ===== sv/tce_queue.sv =====
// two entry queue of classified items between front and back
// depends on tce_pkg
`default_nettype none

module tce_queue import tce_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  inst_t      inst_i,
  output logic       ready_o,
  input  wire logic  pop_i,
  output logic       vld_o,
  output inst_t      head_o
);

  inst_t      mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign vld_o   = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= inst_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tce_addr_mod.sv =====
// data ram address reduction: low bits for a power of two depth,
// otherwise a reciprocal multiply remainder over the S_QUO and S_REM states; depends on tce_pkg
`default_nettype none

module tce_addr_mod import tce_pkg::*; #(
  parameter int unsigned RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_i,
  input  wire logic                         ack_i,
  input  wire logic [WORD_W-1:0]            value_i,
  output logic                              done_o,
  output logic [$clog2(RAM_DEPTH)-1:0]      addr_o
);

  localparam int unsigned     AW    = $clog2(RAM_DEPTH);
  localparam bit              POW2  = ((RAM_DEPTH & (RAM_DEPTH - 1)) == 0);
  localparam int unsigned     SH    = WORD_W + AW;
  localparam int unsigned     PW    = WORD_W + 18;
  localparam longint unsigned RECIP =
    ((longint'(1) << SH) + longint'(RAM_DEPTH) - 1) / longint'(RAM_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_QUO  = 2'd1;
  localparam logic [1:0] S_REM  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          st_q, st_d;
  logic [WORD_W-1:0]   val_q, val_d;
  logic [WORD_W-1:0]   quo_q, quo_d;
  logic [WORD_W-1:0]   rem_q, rem_d;
  logic [PW-1:0]       prod;
  logic [2*WORD_W-1:0] back;

  // quotient by reciprocal, exact for every 16-bit value
  assign prod = PW'(val_q) * PW'(RECIP);
  assign back = (2*WORD_W)'(quo_q) * (2*WORD_W)'(RAM_DEPTH);

  always_comb begin
    st_d  = st_q;
    val_d = val_q;
    quo_d = quo_q;
    rem_d = rem_q;
    unique case (st_q)
      S_IDLE: begin
        if (req_i && !POW2) begin
          st_d  = S_QUO;
          val_d = value_i;
        end
      end
      S_QUO: begin
        quo_d = WORD_W'(prod >> SH);
        st_d  = S_REM;
      end
      S_REM: begin
        rem_d = val_q - back[WORD_W-1:0];
        st_d  = S_DONE;
      end
      S_DONE: begin
        if (ack_i) begin
          st_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = POW2 ? req_i : (st_q == S_DONE);
  assign addr_o = POW2 ? value_i[AW-1:0] : rem_q[AW-1:0];

endmodule

`default_nettype wire

// ===== sv/tce_back.sv =====
// back end: register file, data ram, program counter, execute and result register
// depends on tce_pkg, tce_ram and tce_addr_mod
`default_nettype none

module tce_back import tce_pkg::*; #(
  parameter int unsigned RAM_DEPTH = RAM_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_vld_i,
  input  inst_t                   q_inst_i,
  output logic                    q_pop_o,
  input  wire logic               cfg_we_i,
  input  wire logic [WORD_W-1:0]  cfg_wdata_i,
  output logic [WORD_W-1:0]       origin_o,
  output logic                    clr_busy_o,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic [1:0]              status_o,
  output logic [15:0]             next_pc_o,
  output logic                    out_valid_o,
  output logic [2:0]              out_register_o,
  output logic signed [15:0]      out_value_o
);

  localparam int unsigned AW = $clog2(RAM_DEPTH);

  localparam logic PH_EXEC = 1'b0;
  localparam logic PH_LOAD = 1'b1;

  inst_t             ex_q;
  logic              ex_vld_q;
  logic              phase_q, phase_d;
  logic [2:0]        smp_q;
  logic [NREG-1:0]   rf_vld_q;
  logic              fwd_vld_q;
  logic [RIDX_W-1:0] fwd_idx_q;
  logic [WORD_W-1:0] fwd_data_q;
  logic [WORD_W-1:0] pc_q;
  logic [WORD_W-1:0] origin_q;
  logic              clr_busy_q;
  logic [AW-1:0]     clr_cnt_q;
  logic              res_vld_q;

  logic [WORD_W-1:0] rf_d_rd, rf_s_rd, rf_t_rd;
  logic [WORD_W-1:0] dv, av, bv;
  logic [WORD_W-1:0] dram_rd;
  logic              ok, is_load, is_store, out_free;
  logic              addr_req, addr_done, addr_ack;
  logic [AW-1:0]     addr;
  logic              ex_done, ld_issue, st_we, pop;
  logic              rf_we;
  logic [WORD_W-1:0] alu, rf_wdata;
  logic [WORD_W-1:0] npc;
  logic              dram_we;
  logic [AW-1:0]     dram_waddr;
  logic [WORD_W-1:0] dram_wdata;

  function automatic logic [WORD_W-1:0] pick(logic [RIDX_W-1:0] idx, logic [WORD_W-1:0] rd,
                                             logic v, logic fv, logic [RIDX_W-1:0] fi,
                                             logic [WORD_W-1:0] fd);
    logic [WORD_W-1:0] r;
    if (fv && (fi == idx)) begin
      r = fd;
    end else if (v) begin
      r = rd;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  assign dv = pick(ex_q.rd, rf_d_rd, smp_q[0], fwd_vld_q, fwd_idx_q, fwd_data_q);
  assign av = pick(ex_q.rs, rf_s_rd, smp_q[1], fwd_vld_q, fwd_idx_q, fwd_data_q);
  assign bv = pick(ex_q.rt, rf_t_rd, smp_q[2], fwd_vld_q, fwd_idx_q, fwd_data_q);

  assign ok       = (ex_q.status == ST_OK);
  assign is_load  = ok && (ex_q.opcode == OP_LOAD);
  assign is_store = ok && (ex_q.opcode == OP_STORE);
  assign out_free = !res_vld_q || res_ready_i;
  assign addr_req = ex_vld_q && (is_load || is_store) && (phase_q == PH_EXEC);

  tce_addr_mod #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_addr_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (addr_req),
    .ack_i   (addr_ack),
    .value_i (av),
    .done_o  (addr_done),
    .addr_o  (addr)
  );

  always_comb begin
    ex_done  = 1'b0;
    ld_issue = 1'b0;
    st_we    = 1'b0;
    addr_ack = 1'b0;
    phase_d  = phase_q;
    if (ex_vld_q) begin
      unique case (phase_q)
        PH_EXEC: begin
          if (is_load) begin
            if (addr_done) begin
              ld_issue = 1'b1;
              addr_ack = 1'b1;
              phase_d  = PH_LOAD;
            end
          end else if (is_store) begin
            if (addr_done && out_free) begin
              st_we    = 1'b1;
              addr_ack = 1'b1;
              ex_done  = 1'b1;
            end
          end else if (out_free) begin
            ex_done = 1'b1;
          end
        end
        PH_LOAD: begin
          if (out_free) begin
            ex_done = 1'b1;
            phase_d = PH_EXEC;
          end
        end
        default: phase_d = PH_EXEC;
      endcase
    end
  end

  assign pop     = q_vld_i && (!ex_vld_q || ex_done);
  assign q_pop_o = pop;

  always_comb begin
    unique case (ex_q.opcode)
      OP_MOV:  alu = av;
      OP_MOVI: alu = ex_q.imm2;
      OP_ADD:  alu = av + bv;
      OP_SUB:  alu = av - bv;
      OP_INC:  alu = av + 16'd1;
      OP_DEC:  alu = av - 16'd1;
      OP_AND:  alu = av & bv;
      OP_OR:   alu = av | bv;
      OP_XOR:  alu = av ^ bv;
      OP_NOT:  alu = ~av;
      default: alu = av;
    endcase
  end

  assign rf_we    = ex_done && ok && writes_reg(ex_q.opcode);
  assign rf_wdata = (ex_q.opcode == OP_LOAD) ? dram_rd : alu;

  always_comb begin
    npc = pc_q + 16'd1;
    if (ok) begin
      unique case (ex_q.opcode)
        OP_JMP: npc = origin_q + ex_q.imm1;
        OP_JZ: begin
          if (dv == '0) begin
            npc = origin_q + ex_q.imm2;
          end
        end
        OP_JN: begin
          if (dv[WORD_W-1]) begin
            npc = origin_q + ex_q.imm2;
          end
        end
        default: npc = pc_q + 16'd1;
      endcase
    end
  end

  tce_ram #(.WIDTH (WORD_W), .DEPTH (NREG)) u_rf_d (
    .clk_i (clk_i), .we_i (rf_we), .waddr_i (ex_q.rd), .wdata_i (rf_wdata),
    .re_i (pop), .raddr_i (q_inst_i.rd), .rdata_o (rf_d_rd)
  );
  tce_ram #(.WIDTH (WORD_W), .DEPTH (NREG)) u_rf_s (
    .clk_i (clk_i), .we_i (rf_we), .waddr_i (ex_q.rd), .wdata_i (rf_wdata),
    .re_i (pop), .raddr_i (q_inst_i.rs), .rdata_o (rf_s_rd)
  );
  tce_ram #(.WIDTH (WORD_W), .DEPTH (NREG)) u_rf_t (
    .clk_i (clk_i), .we_i (rf_we), .waddr_i (ex_q.rd), .wdata_i (rf_wdata),
    .re_i (pop), .raddr_i (q_inst_i.rt), .rdata_o (rf_t_rd)
  );

  assign dram_we    = clr_busy_q || st_we;
  assign dram_waddr = clr_busy_q ? clr_cnt_q : addr;
  assign dram_wdata = clr_busy_q ? '0 : dv;

  tce_ram #(.WIDTH (WORD_W), .DEPTH (RAM_DEPTH)) u_dram (
    .clk_i (clk_i), .we_i (dram_we), .waddr_i (dram_waddr), .wdata_i (dram_wdata),
    .re_i (ld_issue), .raddr_i (addr), .rdata_o (dram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q   <= 1'b0;
      phase_q    <= PH_EXEC;
      rf_vld_q   <= '0;
      fwd_vld_q  <= 1'b0;
      pc_q       <= '0;
      origin_q   <= '0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (pop) begin
        ex_vld_q <= 1'b1;
      end else if (ex_done) begin
        ex_vld_q <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_q[ex_q.rd] <= 1'b1;
        fwd_vld_q         <= 1'b1;
      end
      if (cfg_we_i) begin
        origin_q <= cfg_wdata_i;
        pc_q     <= cfg_wdata_i;
      end else if (ex_done) begin
        pc_q <= npc;
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(RAM_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (ex_done) begin
        res_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ex_q  <= q_inst_i;
      smp_q <= {rf_vld_q[q_inst_i.rt], rf_vld_q[q_inst_i.rs], rf_vld_q[q_inst_i.rd]};
    end
    if (rf_we) begin
      fwd_idx_q  <= ex_q.rd;
      fwd_data_q <= rf_wdata;
    end
    if (ex_done) begin
      status_o  <= ex_q.status;
      next_pc_o <= npc;
      if (ok && (ex_q.opcode == OP_OUT)) begin
        out_valid_o    <= 1'b1;
        out_register_o <= ex_q.rd;
        out_value_o    <= dv;
      end else begin
        out_valid_o    <= 1'b0;
        out_register_o <= '0;
        out_value_o    <= '0;
      end
    end
  end

  assign res_valid_o = res_vld_q;
  assign origin_o    = origin_q;
  assign clr_busy_o  = clr_busy_q;

endmodule

`default_nettype wire
